### src/tncc_pkg.sv
// Package for the tagged number converter and comparator.
// Holds command, tag and order codes, the result struct and the
// double ordering, integer-to-double rounding and double-to-integer helpers.
`timescale 1ns / 1ps
package tncc_pkg;

    localparam logic [1:0] CMD_TO_INT64  = 2'd0;
    localparam logic [1:0] CMD_TO_UINT64 = 2'd1;
    localparam logic [1:0] CMD_TO_DOUBLE = 2'd2;
    localparam logic [1:0] CMD_COMPARE   = 2'd3;

    localparam logic [1:0] KIND_SIGNED   = 2'd0;
    localparam logic [1:0] KIND_UNSIGNED = 2'd1;
    localparam logic [1:0] KIND_DOUBLE   = 2'd2;
    localparam logic [1:0] KIND_INVALID  = 2'd3;

    localparam logic [1:0] ORD_LESS    = 2'b11;
    localparam logic [1:0] ORD_EQUAL   = 2'b00;
    localparam logic [1:0] ORD_GREATER = 2'b01;

    typedef struct packed {
        logic        fail;
        logic [63:0] value_bits;
        logic [1:0]  order;
    } result_t;

    // Leading-zero count of a 64-bit word, as a bit-position priority search.
    function automatic logic [6:0] clz64(input logic [63:0] x);
        logic [6:0] n;
        logic       found;
        n = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--)
        begin
            if (!found && x[i])
            begin
                n = 7'(63 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Magnitude plus sign to double with round to nearest even.
    function automatic logic [63:0] mag_to_double(input logic sgn, input logic [63:0] mag);
        logic [6:0]   lz;
        logic [63:0]  norm;
        logic [52:0]  mant;
        logic         guard;
        logic         sticky;
        logic [53:0]  rounded;
        logic [10:0]  expo;
        lz = clz64(mag);
        norm = mag << lz;
        mant = norm[63:11];
        guard = norm[10];
        sticky = |norm[9:0];
        rounded = {1'b0, mant} + 54'(guard && (sticky || mant[0]));
        expo = 11'(11'd1086 - 11'(lz));
        if (mag == 64'd0)
            return {sgn, 63'd0};
        if (rounded[53])
            return {sgn, 11'(expo + 11'd1), 52'd0};
        return {sgn, expo, rounded[51:0]};
    endfunction

    // Integer operand to double bits.
    function automatic logic [63:0] int_to_double(input logic is_signed, input logic [63:0] b);
        logic        neg;
        logic [63:0] mag;
        neg = is_signed && b[63];
        mag = neg ? 64'(~b + 64'd1) : b;
        return mag_to_double(neg, mag);
    endfunction

    // Truncated magnitude of a finite double whose magnitude is below 2^64.
    function automatic logic [63:0] double_trunc_mag(input logic [63:0] d);
        logic [10:0]  e;
        logic [63:0]  sig;
        logic [6:0]   sh;
        e = d[62:52];
        sig = {1'b1, d[51:0], 11'd0};
        sh = 7'(11'd1086 - e);
        if (e < 11'd1023)
            return 64'd0;
        return sig >> sh;
    endfunction

    // IEEE ordering of two double bit patterns, NaN and zero signs handled.
    function automatic logic [1:0] double_order(input logic [63:0] a, input logic [63:0] b);
        logic a_nan;
        logic b_nan;
        logic [63:0] ka;
        logic [63:0] kb;
        a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
        b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
        ka = a[63] ? ~a : (a | 64'h8000000000000000);
        kb = b[63] ? ~b : (b | 64'h8000000000000000);
        if (a_nan || b_nan)
            return ORD_EQUAL;
        if (a[62:0] == 63'd0 && b[62:0] == 63'd0)
            return ORD_EQUAL;
        if (ka < kb)
            return ORD_LESS;
        if (ka > kb)
            return ORD_GREATER;
        return ORD_EQUAL;
    endfunction

endpackage

### src/tncc_core.sv
// Combinational conversion and compare of one registered item.
// Depends on tncc_pkg.
`timescale 1ns / 1ps
module tncc_core
    import tncc_pkg::*;
(
    input  logic [1:0]  command,
    input  logic [1:0]  left_kind,
    input  logic [63:0] left_bits,
    input  logic [1:0]  right_kind,
    input  logic [63:0] right_bits,
    output result_t     result
);

    logic [63:0] l_dbl;
    logic [63:0] r_dbl;
    logic        l_fin;
    logic [63:0] l_mag;
    logic [10:0] l_exp;

    // Operands as doubles and the truncated double magnitude.
    assign l_dbl = (left_kind == KIND_DOUBLE) ? left_bits
                 : int_to_double(left_kind == KIND_SIGNED, left_bits);
    assign r_dbl = (right_kind == KIND_DOUBLE) ? right_bits
                 : int_to_double(right_kind == KIND_SIGNED, right_bits);
    assign l_exp = left_bits[62:52];
    assign l_fin = (l_exp != 11'h7ff);
    assign l_mag = double_trunc_mag(left_bits);

    // Result selection per command.
    always_comb
    begin
        result = '0;
        if (left_kind == KIND_INVALID
            || (command == CMD_COMPARE && right_kind == KIND_INVALID))
        begin
            result.fail = 1'b1;
        end
        else
        begin
            case (command)
                CMD_TO_INT64:
                begin
                    if (left_kind == KIND_DOUBLE)
                    begin
                        // Range is [-2^63, 2^63).
                        if (!l_fin || l_exp > 11'd1086
                            || (l_exp == 11'd1086 && (!left_bits[63] || left_bits[51:0] != 52'd0)))
                            result.fail = 1'b1;
                        else
                            result.value_bits = left_bits[63] ? 64'(~l_mag + 64'd1) : l_mag;
                    end
                    else if (left_kind == KIND_UNSIGNED && left_bits[63])
                        result.fail = 1'b1;
                    else
                        result.value_bits = left_bits;
                end
                CMD_TO_UINT64:
                begin
                    if (left_kind == KIND_DOUBLE)
                    begin
                        // Every negative value fails; only negative zero passes.
                        if (!l_fin || l_exp > 11'd1086
                            || (left_bits[63] && left_bits[62:0] != 63'd0))
                            result.fail = 1'b1;
                        else
                            result.value_bits = l_mag;
                    end
                    else if (left_kind == KIND_SIGNED && left_bits[63])
                        result.fail = 1'b1;
                    else
                        result.value_bits = left_bits;
                end
                CMD_TO_DOUBLE:
                begin
                    result.value_bits = l_dbl;
                end
                default:
                begin
                    if (left_kind == KIND_DOUBLE || right_kind == KIND_DOUBLE)
                        result.order = double_order(l_dbl, r_dbl);
                    else
                    begin
                        logic [63:0] a;
                        logic [63:0] b;
                        a = left_bits ^ {(left_kind == KIND_SIGNED), 63'd0};
                        b = right_bits ^ {(right_kind == KIND_SIGNED), 63'd0};
                        // Mixed kinds: a negative signed operand decides the order
                        // by itself, otherwise both compare as plain unsigned values.
                        if (left_kind != right_kind)
                        begin
                            a = left_bits;
                            b = right_bits;
                        end
                        if (left_kind != right_kind && left_kind == KIND_SIGNED && left_bits[63])
                            result.order = ORD_LESS;
                        else if (left_kind != right_kind && right_kind == KIND_SIGNED
                                 && right_bits[63])
                            result.order = ORD_GREATER;
                        else if (a < b)
                            result.order = ORD_LESS;
                        else if (a > b)
                            result.order = ORD_GREATER;
                        else
                            result.order = ORD_EQUAL;
                    end
                end
            endcase
        end
    end

endmodule

### src/tagged_number_convert_compare.sv
// Tagged number converter and comparator, top level.
//
// Input stream s_axis: one transfer carries a command and up to two tagged
// 64-bit operands. Output stream m_axis: one result transfer per input.
// An accepted item is held in an input register; the core logic then
// computes its result into the output register, which drives tvalid on
// m_axis. Throughput is one item per cycle while m_axis_tready stays
// high, set by the single combinational pass in tncc_core.
// When m_axis stalls, the pipeline holds and s_axis_tready drops only once
// both the input and the output register are full.
// Reset clears both valid flags; no result is pending after reset.
// s_axis_tdata: command[1:0], left_kind[3:2], left_bits[67:4],
//   right_kind[69:68], right_bits[133:70], zero fill to 136 bits.
// m_axis_tdata: fail[0], value_bits[64:1], order[66:65], zero fill to 72.
// Depends on tncc_pkg and tncc_core.
`timescale 1ns / 1ps
module tagged_number_convert_compare
    import tncc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // command, left_kind, left_bits, right_kind, right_bits
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata    // fail, value_bits, order
);

    logic [133:0] in_reg;
    logic         in_valid_reg;
    result_t      out_reg;
    logic         out_valid_reg;
    result_t      res;
    logic         adv;

    tncc_core u_core (
        .command    (in_reg[1:0]),
        .left_kind  (in_reg[3:2]),
        .left_bits  (in_reg[67:4]),
        .right_kind (in_reg[69:68]),
        .right_bits (in_reg[133:70]),
        .result     (res)
    );

    // Input stage moves into the output stage when that one is free.
    assign adv = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {5'd0, out_reg.order, out_reg.value_bits, out_reg.fail};

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_reg <= s_axis_tdata[133:0];
        if (adv)
            out_reg <= res;
    end

endmodule
